FILE: rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared widths, fixed-point constants, register map and the command and
// status types between the motor speed controller's sequencer and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msp_pkg;

    // Field widths
    localparam int DELTA_W   = 15;
    localparam int SPEED_W   = 20;
    localparam int DUTY_W    = 10;
    localparam int REG16_W   = 16;
    localparam int REG10_W   = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int INTEG_W   = 25;
    localparam int TICKS_W   = 10;
    localparam int FRAC_W    = 16;

    // Plant and scaling constants
    localparam longint COUNTS_PER_REV = 8384;
    localparam longint DUTY_MAX       = 1023;
    localparam longint TICK_MS        = 20;
    localparam longint GEAR_NUM       = 131;
    localparam longint FF_RPM_AT_MAX  = 4500;

    // speed = floor(mag * SPD_NUM / COUNTS_PER_REV) = mag*SPD_Q + floor(mag*SPD_R / CPR)
    localparam longint SPD_NUM     = (60000 / TICK_MS) * 256;
    localparam longint SPD_Q       = SPD_NUM / COUNTS_PER_REV;
    localparam longint SPD_R       = SPD_NUM % COUNTS_PER_REV;
    localparam int     RECIP_SHIFT = 40;
    localparam longint SPD_RECIP   = (longint'(1) << RECIP_SHIFT) / COUNTS_PER_REV;

    // ff = floor(target * FF_NUM / FF_RPM_AT_MAX), split the same way
    localparam longint FF_NUM   = GEAR_NUM * DUTY_MAX * 256;
    localparam longint FF_Q     = FF_NUM / FF_RPM_AT_MAX;
    localparam longint FF_R     = FF_NUM % FF_RPM_AT_MAX;
    localparam longint FF_RECIP = (longint'(1) << RECIP_SHIFT) / FF_RPM_AT_MAX;

    // Shared multiplier and intermediate widths
    localparam int MUL_W  = 30;
    localparam int PROD_W = 2 * MUL_W;
    localparam int X_W    = 28;
    localparam int Q_W    = 16;
    localparam int BASE_W = 29;
    localparam int ERR_W  = SPEED_W + 1;
    localparam int SUM_W  = 40;

    // Register reset values
    localparam logic [REG16_W-1:0] TARGET_SPEED_RST     = 16'd5120;
    localparam logic [REG16_W-1:0] PROP_GAIN_RST        = 16'd1280;
    localparam logic [REG16_W-1:0] INTEG_GAIN_RST       = 16'd1966;
    localparam logic [REG10_W-1:0] INTEG_LIMIT_RST      = 10'd250;
    localparam logic [REG10_W-1:0] DUTY_FLOOR_RST       = 10'd250;
    localparam logic [REG10_W-1:0] DUTY_CEILING_RST     = 10'd950;
    localparam logic [REG10_W-1:0] STALL_DUTY_MIN_RST   = 10'd307;
    localparam logic [REG10_W-1:0] STALL_HOLD_TICKS_RST = 10'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SPEED,
        CFG_PROP_GAIN,
        CFG_INTEG_GAIN,
        CFG_INTEG_LIMIT,
        CFG_DUTY_FLOOR,
        CFG_DUTY_CEILING,
        CFG_STALL_DUTY_MIN,
        CFG_STALL_HOLD_TICKS
    } cfg_idx_t;

    typedef struct packed {
        logic [REG16_W-1:0] target_speed;
        logic [REG16_W-1:0] prop_gain;
        logic [REG16_W-1:0] integ_gain;
        logic [REG10_W-1:0] integ_limit;
        logic [REG10_W-1:0] duty_floor;
        logic [REG10_W-1:0] duty_ceiling;
        logic [REG10_W-1:0] stall_duty_min;
        logic [REG10_W-1:0] stall_hold_ticks;
    } cfg_t;

    // Multiplier operand selection
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_MAG_SQ,
        MUL_MAG_SR,
        MUL_X_SREC,
        MUL_Q_SDEN,
        MUL_T_FQ,
        MUL_T_FR,
        MUL_X_FREC,
        MUL_Q_FDEN,
        MUL_IG_ERR,
        MUL_PG_ERR
    } mul_sel_t;

    // What the datapath does with the registered product
    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_BASE,
        ACC_BASE_ERR,
        ACC_X,
        ACC_Q,
        ACC_SPEED,
        ACC_FF,
        ACC_INTEG,
        ACC_SUM,
        ACC_DUTY
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     load;
    } msp_cmd_t;

    typedef struct packed {
        logic active;
    } msp_sts_t;

endpackage

FILE: rtl/core/msp_tick_if.sv
// ----------------------------------------------------------------------------
// msp_tick_if
// Per-tick input channel: encoder count and motion flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface msp_tick_if
    import msp_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [DELTA_W-1:0] encoder_delta;
    logic                      run_en;
    logic                      in_grace;
    logic                      direction;

    modport source (
        output valid,
        output encoder_delta,
        output run_en,
        output in_grace,
        output direction,
        input  ready
    );

    modport sink (
        input  valid,
        input  encoder_delta,
        input  run_en,
        input  in_grace,
        input  direction,
        output ready
    );
endinterface

FILE: rtl/core/msp_report_if.sv
// ----------------------------------------------------------------------------
// msp_report_if
// Per-tick result channel: PWM duties, measured speed and stall flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface msp_report_if
    import msp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               drive_valid;
    logic [DUTY_W-1:0]  pwm_a;
    logic [DUTY_W-1:0]  pwm_b;
    logic [DUTY_W-1:0]  duty_cmd;
    logic [SPEED_W-1:0] measured_speed;
    logic               stall_event;

    modport source (
        output valid,
        output drive_valid,
        output pwm_a,
        output pwm_b,
        output duty_cmd,
        output measured_speed,
        output stall_event,
        input  ready
    );

    modport sink (
        input  valid,
        input  drive_valid,
        input  pwm_a,
        input  pwm_b,
        input  duty_cmd,
        input  measured_speed,
        input  stall_event,
        output ready
    );
endinterface

FILE: rtl/core/msp_cfg.sv
// ----------------------------------------------------------------------------
// msp_cfg
// Control register file, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msp_cfg
    import msp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TARGET_SPEED:     cfg_next.target_speed     = cfg_data[REG16_W-1:0];
                CFG_PROP_GAIN:        cfg_next.prop_gain        = cfg_data[REG16_W-1:0];
                CFG_INTEG_GAIN:       cfg_next.integ_gain       = cfg_data[REG16_W-1:0];
                CFG_INTEG_LIMIT:      cfg_next.integ_limit      = cfg_data[REG10_W-1:0];
                CFG_DUTY_FLOOR:       cfg_next.duty_floor       = cfg_data[REG10_W-1:0];
                CFG_DUTY_CEILING:     cfg_next.duty_ceiling     = cfg_data[REG10_W-1:0];
                CFG_STALL_DUTY_MIN:   cfg_next.stall_duty_min   = cfg_data[REG10_W-1:0];
                CFG_STALL_HOLD_TICKS: cfg_next.stall_hold_ticks = cfg_data[REG10_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_speed     <= TARGET_SPEED_RST;
            cfg_reg.prop_gain        <= PROP_GAIN_RST;
            cfg_reg.integ_gain       <= INTEG_GAIN_RST;
            cfg_reg.integ_limit      <= INTEG_LIMIT_RST;
            cfg_reg.duty_floor       <= DUTY_FLOOR_RST;
            cfg_reg.duty_ceiling     <= DUTY_CEILING_RST;
            cfg_reg.stall_duty_min   <= STALL_DUTY_MIN_RST;
            cfg_reg.stall_hold_ticks <= STALL_HOLD_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/msp_ctrl.sv
// ----------------------------------------------------------------------------
// msp_ctrl
// Sequencer: steps the shared multiplier through the speed, feedforward and
// PI computation and hands the finished word to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msp_ctrl
    import msp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  msp_sts_t sts,
    output msp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPD_Q,
        S_SPD_R,
        S_SPD_REC,
        S_SPD_CHK,
        S_SPD_FIX,
        S_FF_R,
        S_FF_REC,
        S_FF_CHK,
        S_FF_FIX,
        S_INTEG,
        S_SUM,
        S_DUTY,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.capture    = 1'b0;
        cmd.mul_sel    = MUL_NONE;
        cmd.acc_op     = ACC_NONE;
        cmd.load       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SPD_Q;
                end
            end
            S_SPD_Q:
            begin
                cmd.mul_sel = MUL_MAG_SQ;
                state_next  = S_SPD_R;
            end
            S_SPD_R:
            begin
                cmd.mul_sel = MUL_MAG_SR;
                cmd.acc_op  = ACC_BASE;
                state_next  = S_SPD_REC;
            end
            S_SPD_REC:
            begin
                cmd.mul_sel = MUL_X_SREC;
                cmd.acc_op  = ACC_X;
                state_next  = S_SPD_CHK;
            end
            S_SPD_CHK:
            begin
                cmd.mul_sel = MUL_Q_SDEN;
                cmd.acc_op  = ACC_Q;
                state_next  = S_SPD_FIX;
            end
            S_SPD_FIX:
            begin
                cmd.mul_sel = MUL_T_FQ;
                cmd.acc_op  = ACC_SPEED;
                // idle ticks only report speed
                state_next  = sts.active ? S_FF_R : S_LOAD;
            end
            S_FF_R:
            begin
                cmd.mul_sel = MUL_T_FR;
                cmd.acc_op  = ACC_BASE_ERR;
                state_next  = S_FF_REC;
            end
            S_FF_REC:
            begin
                cmd.mul_sel = MUL_X_FREC;
                cmd.acc_op  = ACC_X;
                state_next  = S_FF_CHK;
            end
            S_FF_CHK:
            begin
                cmd.mul_sel = MUL_Q_FDEN;
                cmd.acc_op  = ACC_Q;
                state_next  = S_FF_FIX;
            end
            S_FF_FIX:
            begin
                cmd.mul_sel = MUL_IG_ERR;
                cmd.acc_op  = ACC_FF;
                state_next  = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.mul_sel = MUL_PG_ERR;
                cmd.acc_op  = ACC_INTEG;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.acc_op = ACC_SUM;
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                cmd.acc_op = ACC_DUTY;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/msp_dp.sv
// ----------------------------------------------------------------------------
// msp_dp
// Datapath: one shared signed multiplier with a registered product, the
// reciprocal divide corrections, PI update with clamps, stall tracker and
// the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msp_dp
    import msp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  msp_cmd_t                  cmd,
    output msp_sts_t                  sts,
    input  cfg_t                      cfg,
    input  logic signed [DELTA_W-1:0] encoder_delta,
    input  logic                      run_en,
    input  logic                      in_grace,
    input  logic                      direction,
    output logic                      drive_valid,
    output logic [DUTY_W-1:0]         pwm_a,
    output logic [DUTY_W-1:0]         pwm_b,
    output logic [DUTY_W-1:0]         duty_cmd,
    output logic [SPEED_W-1:0]        measured_speed,
    output logic                      stall_event
);

    localparam int STEP_SHIFT = 8;
    localparam int STEP_W     = 29;
    localparam int ACC_W      = 31;
    localparam int P_W        = 38;
    localparam int RND_W      = DUTY_W + FRAC_W;

    localparam logic signed [ACC_W-1:0] INTEG_HI =
        ACC_W'((longint'(1) << (INTEG_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] INTEG_LO =
        ACC_W'(-(longint'(1) << (INTEG_W - 1)));
    localparam logic [RND_W-1:0] HALF = RND_W'(longint'(1) << (FRAC_W - 1));

    // captured word
    logic [DELTA_W-1:0] mag_reg;
    logic               active_reg;
    logic               grace_reg;
    logic               reverse_reg;

    // working registers
    logic signed [PROD_W-1:0]  prod_reg;
    logic [BASE_W-1:0]         base_reg;
    logic [X_W-1:0]            x_reg;
    logic [Q_W-1:0]            q_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic [BASE_W-1:0]         ff_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [INTEG_W-1:0] integ_new_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [DUTY_W-1:0]         duty_reg;

    // loop state
    logic signed [INTEG_W-1:0] integ_acc_reg;
    logic signed [INTEG_W-1:0] integ_acc_next;
    logic                      stall_tracking_reg;
    logic                      stall_tracking_next;
    logic [TICKS_W-1:0]        stall_ticks_reg;
    logic [TICKS_W-1:0]        stall_ticks_next;

    // output word
    logic               drive_valid_reg;
    logic [DUTY_W-1:0]  pwm_a_reg;
    logic [DUTY_W-1:0]  pwm_b_reg;
    logic [DUTY_W-1:0]  duty_out_reg;
    logic [SPEED_W-1:0] speed_out_reg;
    logic               stall_event_reg;

    logic [DELTA_W-1:0]        mag_next;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [X_W:0]              den;
    logic [X_W:0]              rem;
    logic                      corr;
    logic [BASE_W:0]           qsum;
    logic [SPEED_W-1:0]        speed_sat;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [ACC_W-1:0]   integ_sum;
    logic signed [ACC_W-1:0]   lim;
    logic signed [ACC_W-1:0]   integ_clamp;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   duty_lo;
    logic signed [SUM_W-1:0]   duty_hi;
    logic signed [SUM_W-1:0]   o_clamp;
    logic [RND_W-1:0]          o_rnd;
    logic [DUTY_W-1:0]         duty_next;
    logic                      stalled;
    logic [TICKS_W:0]          ticks_inc;
    logic                      stall_flag;

    assign mag_next = encoder_delta[DELTA_W-1] ? DELTA_W'(-encoder_delta)
                                               : DELTA_W'(encoder_delta);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_MAG_SQ:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(SPD_Q);
            end
            MUL_MAG_SR:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(SPD_R);
            end
            MUL_X_SREC:
            begin
                mul_a = MUL_W'(prod_reg[X_W-1:0]);
                mul_b = MUL_W'(SPD_RECIP);
            end
            MUL_Q_SDEN:
            begin
                mul_a = MUL_W'(prod_reg[RECIP_SHIFT +: Q_W]);
                mul_b = MUL_W'(COUNTS_PER_REV);
            end
            MUL_T_FQ:
            begin
                mul_a = MUL_W'(cfg.target_speed);
                mul_b = MUL_W'(FF_Q);
            end
            MUL_T_FR:
            begin
                mul_a = MUL_W'(cfg.target_speed);
                mul_b = MUL_W'(FF_R);
            end
            MUL_X_FREC:
            begin
                mul_a = MUL_W'(prod_reg[X_W-1:0]);
                mul_b = MUL_W'(FF_RECIP);
            end
            MUL_Q_FDEN:
            begin
                mul_a = MUL_W'(prod_reg[RECIP_SHIFT +: Q_W]);
                mul_b = MUL_W'(FF_RPM_AT_MAX);
            end
            MUL_IG_ERR:
            begin
                mul_a = MUL_W'(cfg.integ_gain);
                mul_b = MUL_W'(err_reg);
            end
            MUL_PG_ERR:
            begin
                mul_a = MUL_W'(cfg.prop_gain);
                mul_b = MUL_W'(err_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Reciprocal quotient is low by at most one: fix with one compare
    always_comb
    begin
        den       = (cmd.acc_op == ACC_FF) ? (X_W + 1)'(FF_RPM_AT_MAX)
                                           : (X_W + 1)'(COUNTS_PER_REV);
        rem       = {1'b0, x_reg} - prod_reg[X_W:0];
        corr      = (rem >= den);
        qsum      = (BASE_W + 1)'(base_reg) + (BASE_W + 1)'(q_reg) + (BASE_W + 1)'(corr);
        speed_sat = (|qsum[BASE_W:SPEED_W]) ? '1 : qsum[SPEED_W-1:0];
        err_next  = $signed({{(ERR_W - REG16_W){1'b0}}, cfg.target_speed})
                  - $signed({1'b0, speed_reg});
    end

    // Integral step (floor of product / 256), limit clamp, then width saturation
    always_comb
    begin
        integ_sum = ACC_W'(integ_acc_reg)
                  + ACC_W'($signed(prod_reg[STEP_SHIFT +: STEP_W]));
        lim       = $signed({{(ACC_W - REG10_W - FRAC_W){1'b0}}, cfg.integ_limit,
                             {FRAC_W{1'b0}}});
        if (integ_sum > lim)
        begin
            integ_clamp = lim;
        end
        else if (integ_sum < -lim)
        begin
            integ_clamp = -lim;
        end
        else
        begin
            integ_clamp = integ_sum;
        end
        if (integ_clamp > INTEG_HI)
        begin
            integ_clamp = INTEG_HI;
        end
        else if (integ_clamp < INTEG_LO)
        begin
            integ_clamp = INTEG_LO;
        end
        integ_next = INTEG_W'(integ_clamp);
    end

    always_comb
    begin
        sum_next = SUM_W'($signed({1'b0, ff_reg}))
                 + SUM_W'($signed(prod_reg[P_W-1:0]))
                 + SUM_W'(integ_new_reg);
        duty_lo  = $signed({{(SUM_W - REG10_W - FRAC_W){1'b0}}, cfg.duty_floor,
                            {FRAC_W{1'b0}}});
        duty_hi  = $signed({{(SUM_W - REG10_W - FRAC_W){1'b0}}, cfg.duty_ceiling,
                            {FRAC_W{1'b0}}});
        o_clamp  = (sum_reg < duty_lo) ? duty_lo : sum_reg;
        // ceiling wins over floor
        if (o_clamp > duty_hi)
        begin
            o_clamp = duty_hi;
        end
        o_rnd     = o_clamp[RND_W-1:0] + HALF;
        duty_next = o_rnd[RND_W-1:FRAC_W];
    end

    // Stall tracker, evaluated when the word is loaded
    always_comb
    begin
        stalled             = (duty_reg >= cfg.stall_duty_min) && !(|speed_reg[SPEED_W-1:8]);
        ticks_inc           = (TICKS_W + 1)'(stall_ticks_reg) + (TICKS_W + 1)'(1);
        stall_flag          = 1'b0;
        integ_acc_next      = integ_acc_reg;
        stall_tracking_next = stall_tracking_reg;
        stall_ticks_next    = stall_ticks_reg;
        if (cmd.load)
        begin
            stall_tracking_next = 1'b0;
            stall_ticks_next    = '0;
            if (!active_reg)
            begin
                integ_acc_next = '0;
            end
            else
            begin
                integ_acc_next = integ_new_reg;
                if (!grace_reg && stalled)
                begin
                    if (!stall_tracking_reg)
                    begin
                        stall_tracking_next = 1'b1;
                    end
                    else if (ticks_inc > (TICKS_W + 1)'(cfg.stall_hold_ticks))
                    begin
                        stall_flag = 1'b1;
                    end
                    else
                    begin
                        stall_tracking_next = 1'b1;
                        stall_ticks_next    = ticks_inc[TICKS_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_acc_reg      <= '0;
            stall_tracking_reg <= 1'b0;
            stall_ticks_reg    <= '0;
        end
        else
        begin
            integ_acc_reg      <= integ_acc_next;
            stall_tracking_reg <= stall_tracking_next;
            stall_ticks_reg    <= stall_ticks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (cmd.capture)
        begin
            mag_reg     <= mag_next;
            active_reg  <= run_en;
            grace_reg   <= in_grace;
            reverse_reg <= direction;
        end

        case (cmd.acc_op)
            ACC_BASE:
            begin
                base_reg <= prod_reg[BASE_W-1:0];
            end
            ACC_BASE_ERR:
            begin
                base_reg <= prod_reg[BASE_W-1:0];
                err_reg  <= err_next;
            end
            ACC_X:     x_reg         <= prod_reg[X_W-1:0];
            ACC_Q:     q_reg         <= prod_reg[RECIP_SHIFT +: Q_W];
            ACC_SPEED: speed_reg     <= speed_sat;
            ACC_FF:    ff_reg        <= qsum[BASE_W-1:0];
            ACC_INTEG: integ_new_reg <= integ_next;
            ACC_SUM:   sum_reg       <= sum_next;
            ACC_DUTY:  duty_reg      <= duty_next;
            default:
            begin
            end
        endcase

        if (cmd.load)
        begin
            speed_out_reg   <= speed_reg;
            drive_valid_reg <= active_reg;
            duty_out_reg    <= active_reg ? duty_reg : '0;
            pwm_a_reg       <= (active_reg && !reverse_reg) ? duty_reg : '0;
            pwm_b_reg       <= (active_reg && reverse_reg) ? duty_reg : '0;
            stall_event_reg <= stall_flag;
        end
    end

    assign sts.active     = active_reg;
    assign drive_valid    = drive_valid_reg;
    assign pwm_a          = pwm_a_reg;
    assign pwm_b          = pwm_b_reg;
    assign duty_cmd       = duty_out_reg;
    assign measured_speed = speed_out_reg;
    assign stall_event    = stall_event_reg;

endmodule

FILE: rtl/core/motor_speed_pi_with_stall_detect.sv
// ----------------------------------------------------------------------------
// motor_speed_pi_with_stall_detect
// Once per control tick a word on tick carries the signed encoder count since
// the last tick and the motion, grace and direction flags. The block turns the
// count into output shaft speed (unsigned Q12.8 RPM), runs a PI loop with a
// target-proportional feedforward and a clamped integral, clamps and rounds
// the duty, steers it to pwm_a (forward) or pwm_b (reverse), and flags a stall
// when a high duty meets near-zero speed for longer than the hold count. One
// result word leaves on report per tick word. A single shared 30x30 signed
// multiplier, used once per cycle by a fixed step sequence, sets the rate: the
// next tick word is accepted once the last result is loaded; an idle tick skips
// the feedforward and PI steps. A result waiting on report does not hold off
// the next tick word; only that word's own finished result waits for the output
// register. Registers are written through cfg_wr_en/cfg_index/cfg_data; the
// user must do so only while no tick is in flight; the block does not check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_speed_pi_with_stall_detect
    import msp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    msp_tick_if.sink             tick,
    msp_report_if.source         report,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t     cfg;
    msp_cmd_t cmd;
    msp_sts_t sts;

    msp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    msp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg            (cfg),
        .encoder_delta  (tick.encoder_delta),
        .run_en         (tick.run_en),
        .in_grace       (tick.in_grace),
        .direction      (tick.direction),
        .drive_valid    (report.drive_valid),
        .pwm_a          (report.pwm_a),
        .pwm_b          (report.pwm_b),
        .duty_cmd       (report.duty_cmd),
        .measured_speed (report.measured_speed),
        .stall_event    (report.stall_event)
    );

endmodule

FILE: rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks on the motor speed controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msp_checker
    import msp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               tick_valid,
    input logic               tick_ready,
    input logic               report_valid,
    input logic               report_ready,
    input logic               drive_valid,
    input logic [DUTY_W-1:0]  pwm_a,
    input logic [DUTY_W-1:0]  pwm_b,
    input logic [DUTY_W-1:0]  duty_cmd,
    input logic [SPEED_W-1:0] measured_speed,
    input logic               stall_event
);

    // an idle tick drives nothing and flags nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !drive_valid
        |-> pwm_a == '0 && pwm_b == '0 && duty_cmd == '0 && !stall_event)
    else $error("idle tick result drives the bridge");

    // exactly the selected channel carries the duty
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && drive_valid
        |-> (pwm_a == '0 || pwm_b == '0) && (pwm_a | pwm_b) == duty_cmd)
    else $error("pwm channels disagree with commanded duty");

    // a stall only comes with a driven tick below 1 RPM
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && stall_event
        |-> drive_valid && measured_speed[SPEED_W-1:8] == '0)
    else $error("stall flagged with speed at or above 1 RPM");

    // one word in flight: no back-to-back acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
    else $error("second tick word accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready
        |=> report_valid && $stable(duty_cmd) && $stable(measured_speed)
            && $stable(stall_event))
    else $error("stalled result word changed");

endmodule

bind motor_speed_pi_with_stall_detect msp_checker u_msp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_valid     (tick.valid),
    .tick_ready     (tick.ready),
    .report_valid   (report.valid),
    .report_ready   (report.ready),
    .drive_valid    (report.drive_valid),
    .pwm_a          (report.pwm_a),
    .pwm_b          (report.pwm_b),
    .duty_cmd       (report.duty_cmd),
    .measured_speed (report.measured_speed),
    .stall_event    (report.stall_event)
);

FILE: verif/tb_motor_speed_pi_with_stall_detect.sv
// ----------------------------------------------------------------------------
// tb_motor_speed_pi_with_stall_detect
// Drives tick words into the speed controller under several register settings
// and checks every report word against an in-bench PI / stall predictor. The
// run covers field extremes, saturation, floor above ceiling and stall
// timing, then random motion runs with random idling on both channels, and
// ends with a steady stretch without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_motor_speed_pi_with_stall_detect;
    import msp_pkg::*;

    // Own plant scaling: RPM Q12.8 per count and feedforward ratio
    localparam longint SPEED_NUM   = 768000;
    localparam longint SPEED_DEN   = 8384;
    localparam longint FF_MUL      = 131 * 1023 * 256;
    localparam longint FF_DIV      = 4500;
    localparam longint SPEED_SAT   = 1048575;
    localparam longint ACC_POS_MAX = 16777215;
    localparam longint ACC_NEG_MIN = -16777216;
    localparam longint ONE_RPM     = 256;
    localparam int     COUNT_SAT   = 1023;

    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic               active;
        logic               grace;
        logic               reverse;
    } tick_word_t;

    typedef struct packed {
        logic               drive_valid;
        logic [DUTY_W-1:0]  pwm_a;
        logic [DUTY_W-1:0]  pwm_b;
        logic [DUTY_W-1:0]  duty;
        logic [SPEED_W-1:0] speed;
        logic               stall;
    } drive_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    msp_tick_if   tick_bus ();
    msp_report_if report_bus ();

    motor_speed_pi_with_stall_detect DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_bus),
        .report    (report_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state and its copy of the registers
    cfg_t          loop_cfg;
    longint        integ_q16;
    bit            stall_armed;
    int unsigned   stall_count;

    drive_report_t expected_drive[$];
    int unsigned   mismatch_count = 0;
    bit            jitter_on      = 1'b1;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("motor_speed_pi_with_stall_detect: mismatch");
        $finish;
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns drive report %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void reset_predictor();
        loop_cfg.target_speed     = TARGET_SPEED_RST;
        loop_cfg.prop_gain        = PROP_GAIN_RST;
        loop_cfg.integ_gain       = INTEG_GAIN_RST;
        loop_cfg.integ_limit      = INTEG_LIMIT_RST;
        loop_cfg.duty_floor       = DUTY_FLOOR_RST;
        loop_cfg.duty_ceiling     = DUTY_CEILING_RST;
        loop_cfg.stall_duty_min   = STALL_DUTY_MIN_RST;
        loop_cfg.stall_hold_ticks = STALL_HOLD_TICKS_RST;
        integ_q16   = 0;
        stall_armed = 1'b0;
        stall_count = 0;
    endfunction

    function automatic drive_report_t predict_drive(input tick_word_t tw);
        drive_report_t r;
        longint        mag, spd, err, ff, lim, o, duty;
        int unsigned   nxt;
        r   = '0;
        mag = longint'($signed(tw.delta));
        if (mag < 0)
            mag = -mag;
        spd = mag * SPEED_NUM / SPEED_DEN;
        if (spd > SPEED_SAT)
            spd = SPEED_SAT;
        r.speed = spd[SPEED_W-1:0];
        if (!tw.active)
        begin
            integ_q16   = 0;
            stall_armed = 1'b0;
            stall_count = 0;
            return r;
        end
        err = longint'(loop_cfg.target_speed) - spd;
        ff  = longint'(loop_cfg.target_speed) * FF_MUL / FF_DIV;
        lim = longint'(loop_cfg.integ_limit) * 65536;
        // floor divide by 256
        integ_q16 += (longint'(loop_cfg.integ_gain) * err) >>> 8;
        if (integ_q16 > lim)         integ_q16 = lim;
        if (integ_q16 < -lim)        integ_q16 = -lim;
        if (integ_q16 > ACC_POS_MAX) integ_q16 = ACC_POS_MAX;
        if (integ_q16 < ACC_NEG_MIN) integ_q16 = ACC_NEG_MIN;
        o = ff + longint'(loop_cfg.prop_gain) * err + integ_q16;
        if (o < longint'(loop_cfg.duty_floor) * 65536)
            o = longint'(loop_cfg.duty_floor) * 65536;
        if (o > longint'(loop_cfg.duty_ceiling) * 65536)
            o = longint'(loop_cfg.duty_ceiling) * 65536;
        duty = (o + 32768) / 65536;
        r.drive_valid = 1'b1;
        r.duty        = duty[DUTY_W-1:0];
        if (tw.reverse)
            r.pwm_b = duty[DUTY_W-1:0];
        else
            r.pwm_a = duty[DUTY_W-1:0];
        if (tw.grace)
        begin
            stall_armed = 1'b0;
            stall_count = 0;
        end
        else if (duty >= longint'(loop_cfg.stall_duty_min) && spd < ONE_RPM)
        begin
            if (!stall_armed)
            begin
                stall_armed = 1'b1;
                stall_count = 0;
            end
            else
            begin
                nxt = stall_count + 1;
                if (nxt > loop_cfg.stall_hold_ticks)
                begin
                    r.stall     = 1'b1;
                    stall_armed = 1'b0;
                    stall_count = 0;
                end
                else
                    stall_count = (nxt > COUNT_SAT) ? COUNT_SAT : nxt;
            end
        end
        else
        begin
            stall_armed = 1'b0;
            stall_count = 0;
        end
        return r;
    endfunction

    function automatic tick_word_t make_tick(input int d, input bit a, input bit g, input bit r);
        tick_word_t tw;
        tw.delta   = d[DELTA_W-1:0];
        tw.active  = a;
        tw.grace   = g;
        tw.reverse = r;
        return tw;
    endfunction

    // Hold valid high across back-to-back words; drop it only for a gap
    task automatic send_tick(input tick_word_t tw);
        if (jitter_on && $urandom_range(0, 3) == 0)
        begin
            tick_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        tick_bus.valid         <= 1'b1;
        tick_bus.encoder_delta <= tw.delta;
        tick_bus.run_en        <= tw.active;
        tick_bus.in_grace      <= tw.grace;
        tick_bus.direction     <= tw.reverse;
        @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
        expected_drive.push_back(predict_drive(tw));
    endtask

    task automatic wait_drained();
        tick_bus.valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic apply_cfg(input cfg_t c);
        cfg_idx_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            // junk above the 10-bit registers must be dropped
            case (idx)
                CFG_TARGET_SPEED:   cfg_data <= c.target_speed;
                CFG_PROP_GAIN:      cfg_data <= c.prop_gain;
                CFG_INTEG_GAIN:     cfg_data <= c.integ_gain;
                CFG_INTEG_LIMIT:    cfg_data <= {6'($urandom), c.integ_limit};
                CFG_DUTY_FLOOR:     cfg_data <= {6'($urandom), c.duty_floor};
                CFG_DUTY_CEILING:   cfg_data <= {6'($urandom), c.duty_ceiling};
                CFG_STALL_DUTY_MIN: cfg_data <= {6'($urandom), c.stall_duty_min};
                default:            cfg_data <= {6'($urandom), c.stall_hold_ticks};
            endcase
            @(posedge clk);
            idx = idx.next();
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        loop_cfg = c;
    endtask

    function automatic int unsigned pick_value(input int unsigned hi, input int unsigned usual);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(0, usual);
        endcase
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        c.target_speed   = REG16_W'(pick_value(65535, 20000));
        c.prop_gain      = REG16_W'(pick_value(65535, 4000));
        c.integ_gain     = REG16_W'(pick_value(65535, 8000));
        c.integ_limit    = REG10_W'(pick_value(1023, 600));
        c.duty_floor     = REG10_W'(pick_value(1023, 400));
        c.duty_ceiling   = REG10_W'(pick_value(1023, 1023));
        c.stall_duty_min = REG10_W'(pick_value(1023, 700));
        if ($urandom_range(0, 3) != 0)
            c.stall_hold_ticks = REG10_W'($urandom_range(1, 8));
        else
            c.stall_hold_ticks = REG10_W'($urandom_range(1, 1023));
        return c;
    endfunction

    // Mostly motion runs (grace lead-in, fixed direction), some noise and idle bursts
    task automatic run_motion(input int unsigned count);
        int unsigned sent, len, lead, shape, i;
        int          aim, d;
        bit          rev, grace;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    send_tick(make_tick($urandom_range(0, 32767), 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                    sent++;
                end
                1:
                begin
                    len = $urandom_range(1, 3);
                    for (i = 0; i < len && sent < count; i++)
                    begin
                        send_tick(make_tick($urandom_range(0, 20000) - 10000, 1'b0,
                                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                        sent++;
                    end
                end
                default:
                begin
                    len   = $urandom_range(3, 40);
                    lead  = $urandom_range(0, 3);
                    rev   = 1'($urandom_range(0, 1));
                    shape = $urandom_range(0, 2);
                    aim   = loop_cfg.target_speed * 8384 / 768000;
                    for (i = 0; i < len && sent < count; i++)
                    begin
                        case (shape)
                            0:       d = $urandom_range(0, 6) - 3;
                            1:       d = aim + $urandom_range(0, 16) - 8;
                            default: d = $urandom_range(0, 20000) - 10000;
                        endcase
                        if (rev && shape != 2)
                            d = -d;
                        grace = (i < lead) || ($urandom_range(0, 19) == 0);
                        send_tick(make_tick(d, 1'b1, grace, rev));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_reset_defaults();
        send_tick(make_tick(0, 1, 0, 0));
        send_tick(make_tick(56, 1, 0, 0));
        send_tick(make_tick(-56, 1, 0, 1));
        send_tick(make_tick(16383, 1, 0, 0));
        send_tick(make_tick(-16384, 1, 0, 1));
        send_tick(make_tick(10000, 1, 0, 0));
        send_tick(make_tick(-10000, 1, 0, 1));
        send_tick(make_tick(3, 0, 1, 1));
        send_tick(make_tick(0, 1, 1, 0));
        send_tick(make_tick(2, 1, 0, 0));
        send_tick(make_tick(-2, 1, 0, 1));
        send_tick(make_tick(3, 1, 0, 0));
        wait_drained();
    endtask

    // Saturated integral with floor above ceiling, then zero gains with fastest stall
    task automatic test_config_extremes();
        cfg_t c;
        c = '{target_speed: 16'hFFFF, prop_gain: 16'hFFFF, integ_gain: 16'hFFFF,
              integ_limit: 10'd1023, duty_floor: 10'd1023, duty_ceiling: 10'd0,
              stall_duty_min: 10'd0, stall_hold_ticks: 10'd1023};
        apply_cfg(c);
        send_tick(make_tick(0, 1, 0, 0));
        send_tick(make_tick(0, 1, 0, 1));
        send_tick(make_tick(-16384, 1, 0, 1));
        send_tick(make_tick(16383, 1, 0, 0));
        send_tick(make_tick(0, 1, 0, 0));
        wait_drained();
        c = '{target_speed: 16'd0, prop_gain: 16'd0, integ_gain: 16'd0,
              integ_limit: 10'd0, duty_floor: 10'd0, duty_ceiling: 10'd1023,
              stall_duty_min: 10'd0, stall_hold_ticks: 10'd1};
        apply_cfg(c);
        send_tick(make_tick(0, 1, 0, 0));
        send_tick(make_tick(1, 1, 0, 0));
        send_tick(make_tick(-2, 1, 0, 1));
        send_tick(make_tick(0, 1, 1, 0));
        send_tick(make_tick(0, 1, 0, 0));
        send_tick(make_tick(2, 1, 0, 0));
        send_tick(make_tick(0, 1, 0, 0));
        wait_drained();
    endtask

    task automatic test_random_settings();
        cfg_t c;
        for (int p = 0; p < 5; p++)
        begin
            c = rand_cfg();
            if (p == 1)
                c.stall_hold_ticks = 10'd1023;
            if (p == 2)
                c.stall_hold_ticks = 10'd1;
            apply_cfg(c);
            run_motion(50);
            // hold the sender until every report is back
            if (p == 3)
                wait_drained();
            run_motion(50);
            wait_drained();
        end
    endtask

    task automatic test_steady_run();
        jitter_on = 1'b0;
        apply_cfg(rand_cfg());
        run_motion(100);
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        tick_bus.valid         = 1'b0;
        tick_bus.encoder_delta = '0;
        tick_bus.run_en        = 1'b0;
        tick_bus.in_grace      = 1'b0;
        tick_bus.direction     = 1'b0;
        reset_predictor();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_random_settings();
        test_steady_run();
        tick_bus.valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("motor_speed_pi_with_stall_detect: match");
        else
            $display("motor_speed_pi_with_stall_detect: mismatch");
        $finish;
    end

    // Receiver side: stall ready in bursts while jitter is on
    initial
    begin
        report_bus.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (jitter_on && $urandom_range(0, 4) == 0)
            begin
                report_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            report_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_report
        drive_report_t want;
        if (rst_n && report_bus.valid && report_bus.ready)
        begin
            if (expected_drive.size() == 0)
                flag_mismatch("word with nothing pending", longint'(report_bus.duty_cmd), 0);
            else
            begin
                want = expected_drive.pop_front();
                if (report_bus.drive_valid !== want.drive_valid)
                    flag_mismatch("drive_valid", longint'(report_bus.drive_valid),
                                  longint'(want.drive_valid));
                if (report_bus.pwm_a !== want.pwm_a)
                    flag_mismatch("pwm_a", longint'(report_bus.pwm_a), longint'(want.pwm_a));
                if (report_bus.pwm_b !== want.pwm_b)
                    flag_mismatch("pwm_b", longint'(report_bus.pwm_b), longint'(want.pwm_b));
                if (report_bus.duty_cmd !== want.duty)
                    flag_mismatch("duty_cmd", longint'(report_bus.duty_cmd),
                                  longint'(want.duty));
                if (report_bus.measured_speed !== want.speed)
                    flag_mismatch("measured_speed", longint'(report_bus.measured_speed),
                                  longint'(want.speed));
                if (report_bus.stall_event !== want.stall)
                    flag_mismatch("stall_event", longint'(report_bus.stall_event),
                                  longint'(want.stall));
            end
        end
    end

endmodule
